[rtl/core/dpsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual encoder PI speed control package
// Shared widths, operation codes, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package dpsc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int SPEED_WIDTH = 16;
  localparam int GAIN_WIDTH  = 8;
  localparam int DRIVE_WIDTH = 32;
  localparam int ERR_WIDTH   = SPEED_WIDTH + 1;
  localparam int PROD_WIDTH  = ERR_WIDTH + GAIN_WIDTH + 1;
  localparam int SUM_WIDTH   = DRIVE_WIDTH + 1;
  localparam int EXT_WIDTH   = 33;

  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [SPEED_WIDTH-1:0] speed_t;
  typedef logic        [GAIN_WIDTH-1:0]  gain_t;
  typedef logic signed [DRIVE_WIDTH-1:0] drive_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  localparam logic [1:0] OP_EDGE_ONE = 2'd0;
  localparam logic [1:0] OP_EDGE_TWO = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [1:0] REG_TARGET      = 2'd0;
  localparam logic [1:0] REG_GAIN_P_RIGHT = 2'd1;
  localparam logic [1:0] REG_GAIN_P_LEFT = 2'd2;
  localparam logic [1:0] REG_GAIN_I      = 2'd3;

  localparam speed_t TARGET_RESET = '0;
  localparam gain_t  GAIN_P_RESET = 8'd10;
  localparam gain_t  GAIN_I_RESET = 8'd3;

  localparam count_t CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam count_t CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  localparam drive_t DRIVE_MAX = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
  localparam drive_t DRIVE_MIN = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};

  function automatic drive_t sat_drive(input sum_t v);
    drive_t r;
    if (v[SUM_WIDTH-1] != v[SUM_WIDTH-2]) begin
      r = v[SUM_WIDTH-1] ? DRIVE_MIN : DRIVE_MAX;
    end else begin
      r = v[DRIVE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/dpsc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual encoder PI speed control request channel
// Valid/ready channel carrying one encoder edge or control tick request.
// ----------------------------------------------------------------------------
interface dpsc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic              phase_a;
  logic              phase_b;
  logic signed [15:0] speed_right;
  logic signed [15:0] speed_left;

  modport source (output valid, operation, phase_a, phase_b, speed_right, speed_left,
                  input ready);
  modport sink (input valid, operation, phase_a, phase_b, speed_right, speed_left,
                output ready);
endinterface

[rtl/core/dpsc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual encoder PI speed control result channel
// Valid/ready channel carrying the counts and drive values of one tick.
// ----------------------------------------------------------------------------
interface dpsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] count_one;
  logic signed [15:0] count_two;
  logic signed [31:0] drive_right;
  logic signed [31:0] drive_left;

  modport source (output valid, count_one, count_two, drive_right, drive_left,
                  input ready);
  modport sink (input valid, count_one, count_two, drive_right, drive_left,
                output ready);
endinterface

[rtl/core/dpsc_enc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature edge counter
// Saturating signed edge counter with clear and a 16-bit saturated view.
// ----------------------------------------------------------------------------
module dpsc_enc
  import dpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic               clear_en,
  input  logic               phase_a,
  input  logic               phase_b,
  output logic signed [15:0] count_sat
);

  count_t                        count;
  count_t                        count_next;
  logic signed [EXT_WIDTH-1:0]   count_ext;

  always_comb begin
    count_next = count;
    if (clear_en) begin
      count_next = '0;
    end else if (step_en) begin
      if (phase_a == phase_b) begin
        if (count != CNT_MAX) begin
          count_next = count + count_t'(1);
        end
      end else begin
        if (count != CNT_MIN) begin
          count_next = count - count_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign count_ext = {{(EXT_WIDTH-COUNT_WIDTH){count[COUNT_WIDTH-1]}}, count};

  always_comb begin
    if (count_ext > 33'sd32767) begin
      count_sat = 16'sh7FFF;
    end else if (count_ext < -33'sd32768) begin
      count_sat = 16'sh8000;
    end else begin
      count_sat = count_ext[15:0];
    end
  end

endmodule

[rtl/core/dpsc_pi.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI speed controller
// One motor's integrator and saturated proportional plus integral drive.
// ----------------------------------------------------------------------------
module dpsc_pi
  import dpsc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   update_en,
  input  speed_t target,
  input  speed_t speed,
  input  gain_t  gain_p,
  input  gain_t  gain_i,
  output drive_t drive
);

  drive_t                        integral;
  drive_t                        integral_next;
  logic signed [ERR_WIDTH-1:0]   err;
  logic signed [PROD_WIDTH-1:0]  prod_i;
  logic signed [PROD_WIDTH-1:0]  prod_p;
  sum_t                          sum_i;
  sum_t                          sum_d;

  assign err    = {target[SPEED_WIDTH-1], target} - {speed[SPEED_WIDTH-1], speed};
  assign prod_i = err * $signed({1'b0, gain_i});
  assign prod_p = err * $signed({1'b0, gain_p});

  assign sum_i = {integral[DRIVE_WIDTH-1], integral}
               + {{(SUM_WIDTH-PROD_WIDTH){prod_i[PROD_WIDTH-1]}}, prod_i};
  assign integral_next = sat_drive(sum_i);

  assign sum_d = {integral_next[DRIVE_WIDTH-1], integral_next}
               + {{(SUM_WIDTH-PROD_WIDTH){prod_p[PROD_WIDTH-1]}}, prod_p};
  assign drive = sat_drive(sum_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (update_en) begin
      integral <= integral_next;
    end
  end

endmodule

[rtl/core/dual_encoder_pi_speed_control_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual encoder PI speed control unit
// Two quadrature edge counters and two PI speed loops behind valid/ready
// channels and an APB-style register port.
// ----------------------------------------------------------------------------
// A request is registered on acceptance and processed from that register; a
// tick result is registered. One request is taken per cycle unless a tick
// request waits on a full result register; an edge request gives no result.
// The limit is both PI loops' multiply-add paths from the request register
// into the integrators and the result register, which holds a finished result
// while edge requests are taken. Registers sit at byte addresses 0, 4, 8 and
// 12; the user must write them only while idle; the block does not enforce it.
module dual_encoder_pi_speed_control_unit
  import dpsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  dpsc_in_if.sink                   cmd,
  dpsc_out_if.source                res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  speed_t target_speed;
  gain_t  gain_p_right;
  gain_t  gain_p_left;
  gain_t  gain_i;

  logic       req_valid;
  logic [1:0] req_op;
  logic       req_a;
  logic       req_b;
  speed_t     req_speed_right;
  speed_t     req_speed_left;

  logic       out_free;
  logic       fire;
  logic       edge_one;
  logic       edge_two;
  logic       tick;

  logic signed [15:0] count_one;
  logic signed [15:0] count_two;
  drive_t             drive_right;
  drive_t             drive_left;

  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed <= TARGET_RESET;
      gain_p_right <= GAIN_P_RESET;
      gain_p_left  <= GAIN_P_RESET;
      gain_i       <= GAIN_I_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TARGET:       target_speed <= pwdata[SPEED_WIDTH-1:0];
        REG_GAIN_P_RIGHT: gain_p_right <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_P_LEFT:  gain_p_left  <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_I:       gain_i       <= pwdata[GAIN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TARGET:       prdata = {16'b0, target_speed};
      REG_GAIN_P_RIGHT: prdata = {24'b0, gain_p_right};
      REG_GAIN_P_LEFT:  prdata = {24'b0, gain_p_left};
      REG_GAIN_I:       prdata = {24'b0, gain_i};
      default:          prdata = '0;
    endcase
  end

  assign out_free  = !res.valid || res.ready;
  assign fire      = req_valid && ((req_op != OP_TICK) || out_free);
  assign cmd.ready = !req_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (cmd.ready) begin
      req_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      req_op          <= cmd.operation;
      req_a           <= cmd.phase_a;
      req_b           <= cmd.phase_b;
      req_speed_right <= cmd.speed_right;
      req_speed_left  <= cmd.speed_left;
    end
  end

  always_comb begin
    edge_one = 1'b0;
    edge_two = 1'b0;
    tick     = 1'b0;
    case (req_op)
      OP_EDGE_ONE: edge_one = fire;
      OP_EDGE_TWO: edge_two = fire;
      OP_TICK:     tick     = fire;
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  dpsc_enc u_enc_one (
    .clk       (clk),
    .rst       (rst),
    .step_en   (edge_one),
    .clear_en  (tick),
    .phase_a   (req_a),
    .phase_b   (req_b),
    .count_sat (count_one)
  );

  dpsc_enc u_enc_two (
    .clk       (clk),
    .rst       (rst),
    .step_en   (edge_two),
    .clear_en  (tick),
    .phase_a   (req_a),
    .phase_b   (req_b),
    .count_sat (count_two)
  );

  dpsc_pi u_pi_right (
    .clk       (clk),
    .rst       (rst),
    .update_en (tick),
    .target    (target_speed),
    .speed     (req_speed_right),
    .gain_p    (gain_p_right),
    .gain_i    (gain_i),
    .drive     (drive_right)
  );

  dpsc_pi u_pi_left (
    .clk       (clk),
    .rst       (rst),
    .update_en (tick),
    .target    (target_speed),
    .speed     (req_speed_left),
    .gain_p    (gain_p_left),
    .gain_i    (gain_i),
    .drive     (drive_left)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (tick) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      res.count_one   <= count_one;
      res.count_two   <= count_two;
      res.drive_right <= drive_right;
      res.drive_left  <= drive_left;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual encoder PI speed control unit testbench
// Drives encoder edge, tick and idle requests through the request channel,
// retunes the loop over the register port between phases, and checks every
// tick result against set values or a local model of counters and PI integrators.
// ----------------------------------------------------------------------------
module testbench
  import dpsc_pkg::*;
();

  typedef struct packed {
    logic [1:0] op;
    logic       phase_a;
    logic       phase_b;
    speed_t     speed_right;
    speed_t     speed_left;
  } request_t;

  typedef struct packed {
    count_t count_one;
    count_t count_two;
    drive_t drive_right;
    drive_t drive_left;
  } tick_report_t;

  typedef struct packed {
    request_t     rq;
    logic         typed;
    tick_report_t want;
  } directed_row_t;

  localparam tick_report_t NO_REPORT = '0;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  dpsc_in_if  cmd ();
  dpsc_out_if res ();

  dual_encoder_pi_speed_control_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .res    (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Loop state as the block should hold it.
  speed_t set_speed;
  gain_t  kp_right;
  gain_t  kp_left;
  gain_t  ki_shared;
  count_t enc_one_count;
  count_t enc_two_count;
  drive_t integ_right;
  drive_t integ_left;

  tick_report_t pending_reports[$];
  int           fault_count = 0;
  int           send_calm = 0;
  int           recv_calm = 0;
  int           recv_hold = 0;

  directed_row_t directed_rows [15] = '{
    '{'{OP_TICK, 1'b0, 1'b0, 16'sh0000, 16'sh0000}, 1'b1,
      '{16'sh0000, 16'sh0000, 32'sh0, 32'sh0}},
    '{'{OP_EDGE_ONE, 1'b0, 1'b0, 16'sh0000, 16'sh0000}, 1'b0, NO_REPORT},
    '{'{OP_EDGE_ONE, 1'b1, 1'b1, 16'sh0000, 16'sh0000}, 1'b0, NO_REPORT},
    '{'{OP_EDGE_ONE, 1'b0, 1'b1, 16'sh0000, 16'sh0000}, 1'b0, NO_REPORT},
    '{'{OP_EDGE_ONE, 1'b1, 1'b0, 16'sh0000, 16'sh0000}, 1'b0, NO_REPORT},
    '{'{OP_EDGE_ONE, 1'b1, 1'b1, 16'shffff, 16'shffff}, 1'b0, NO_REPORT},
    '{'{OP_EDGE_TWO, 1'b0, 1'b1, 16'sh7fff, 16'sh8000}, 1'b0, NO_REPORT},
    '{'{OP_NONE, 1'b1, 1'b1, 16'sh1234, 16'shedcb}, 1'b0, NO_REPORT},
    '{'{OP_TICK, 1'b0, 1'b0, 16'sh0000, 16'sh0000}, 1'b1,
      '{16'sh0001, 16'shffff, 32'sh0, 32'sh0}},
    '{'{OP_TICK, 1'b1, 1'b0, 16'sh0001, 16'shffff}, 1'b1,
      '{16'sh0000, 16'sh0000, -32'sd13, 32'sd13}},
    '{'{OP_TICK, 1'b0, 1'b1, 16'sh8000, 16'sh7fff}, 1'b0, NO_REPORT},
    '{'{OP_TICK, 1'b1, 1'b1, 16'sh7fff, 16'sh8000}, 1'b0, NO_REPORT},
    '{'{OP_NONE, 1'b0, 1'b0, 16'sh0000, 16'sh0000}, 1'b0, NO_REPORT},
    '{'{OP_EDGE_TWO, 1'b0, 1'b0, 16'sh5555, 16'shaaaa}, 1'b0, NO_REPORT},
    '{'{OP_TICK, 1'b1, 1'b0, 16'sh5a5a, 16'sha5a5}, 1'b0, NO_REPORT}
  };

  function automatic drive_t saturate_drive(input longint v);
    if (v > longint'(DRIVE_MAX)) return DRIVE_MAX;
    if (v < longint'(DRIVE_MIN)) return DRIVE_MIN;
    return drive_t'(v);
  endfunction

  function automatic count_t step_count(input count_t c, input logic a, input logic b);
    if (a == b) return (c == CNT_MAX) ? c : c + 16'sd1;
    return (c == CNT_MIN) ? c : c - 16'sd1;
  endfunction

  function automatic drive_t pi_update(inout drive_t integ, input speed_t meas,
                                       input gain_t kp);
    longint err;
    err = longint'(set_speed) - longint'(meas);
    integ = saturate_drive(longint'(integ) + err * longint'(ki_shared));
    return saturate_drive(err * longint'(kp) + longint'(integ));
  endfunction

  function automatic bit track_request(input request_t rq, output tick_report_t rpt);
    rpt = NO_REPORT;
    case (rq.op)
      OP_EDGE_ONE: enc_one_count = step_count(enc_one_count, rq.phase_a, rq.phase_b);
      OP_EDGE_TWO: enc_two_count = step_count(enc_two_count, rq.phase_a, rq.phase_b);
      OP_TICK: begin
        rpt.count_one = enc_one_count;
        rpt.count_two = enc_two_count;
        enc_one_count = '0;
        enc_two_count = '0;
        rpt.drive_right = pi_update(integ_right, rq.speed_right, kp_right);
        rpt.drive_left = pi_update(integ_left, rq.speed_left, kp_left);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Alternates stretches of back-to-back traffic with stretches of random gaps.
  function automatic int draw_gap(inout int calm);
    if (calm == 0) begin
      calm = ($urandom_range(0, 2) == 0) ? int'($urandom_range(5, 30))
                                          : -int'($urandom_range(5, 30));
    end
    if (calm > 0) begin
      calm--;
      return 0;
    end
    calm++;
    return $urandom_range(0, 11);
  endfunction

  function automatic speed_t random_speed(input bit pinned);
    if (pinned && $urandom_range(0, 4) != 0) begin
      return set_speed[15] ? 16'sh7fff : 16'sh8000;
    end
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return speed_t'($urandom);
    endcase
  endfunction

  function automatic request_t random_request(input int tick_pct, input bit pinned);
    request_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      rq.op = OP_TICK;
    end else begin
      pick = $urandom_range(0, 19);
      rq.op = (pick == 0) ? OP_NONE : (pick < 10) ? OP_EDGE_ONE : OP_EDGE_TWO;
    end
    rq.phase_a = 1'($urandom_range(0, 1));
    rq.phase_b = 1'($urandom_range(0, 1));
    rq.speed_right = random_speed(pinned);
    rq.speed_left = random_speed(pinned);
    return rq;
  endfunction

  function automatic request_t edge_request(input logic [1:0] op, input bit up);
    request_t rq;
    rq.op = op;
    rq.phase_a = 1'($urandom_range(0, 1));
    rq.phase_b = up ? rq.phase_a : ~rq.phase_a;
    rq.speed_right = speed_t'($urandom);
    rq.speed_left = speed_t'($urandom);
    return rq;
  endfunction

  task automatic send_request(input request_t rq, input int gap, input bit typed = 1'b0,
                              input tick_report_t typed_rpt = NO_REPORT);
    tick_report_t rpt;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.operation <= rq.op;
    cmd.phase_a <= rq.phase_a;
    cmd.phase_b <= rq.phase_b;
    cmd.speed_right <= rq.speed_right;
    cmd.speed_left <= rq.speed_left;
    do @(posedge clk); while (!cmd.ready);
    if (track_request(rq, rpt)) begin
      pending_reports.push_back(typed ? typed_rpt : rpt);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic retune(input speed_t tgt, input gain_t kpr, input gain_t kpl,
                        input gain_t ki);
    cmd.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_TARGET, {{16{tgt[15]}}, tgt});
    write_reg(REG_GAIN_P_RIGHT, {24'd0, kpr});
    write_reg(REG_GAIN_P_LEFT, {24'd0, kpl});
    write_reg(REG_GAIN_I, {24'd0, ki});
    set_speed = tgt;
    kp_right = kpr;
    kp_left = kpl;
    ki_shared = ki;
  endtask

  task automatic retune_random();
    retune(speed_t'($urandom), gain_t'($urandom), gain_t'($urandom), gain_t'($urandom));
  endtask

  task automatic run_phase(input int items, input int tick_pct, input bit pinned);
    repeat (items) send_request(random_request(tick_pct, pinned), draw_gap(send_calm));
  endtask

  initial begin : stimulus
    request_t rq;
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.operation <= OP_NONE;
    cmd.phase_a <= 1'b0;
    cmd.phase_b <= 1'b0;
    cmd.speed_right <= '0;
    cmd.speed_left <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    set_speed = TARGET_RESET;
    kp_right = GAIN_P_RESET;
    kp_left = GAIN_P_RESET;
    ki_shared = GAIN_I_RESET;
    enc_one_count = '0;
    enc_two_count = '0;
    integ_right = '0;
    integ_left = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, draw_gap(send_calm), directed_rows[i].typed,
                   directed_rows[i].want);
    end

    // Run the two counters in opposite directions back to back before a tick.
    repeat (20) begin
      send_request(edge_request(OP_EDGE_ONE, 1'b1), 0);
      send_request(edge_request(OP_EDGE_TWO, 1'b0), 0);
    end
    rq = edge_request(OP_TICK, 1'b1);
    send_request(rq, 0);

    retune_random();
    run_phase(180, 25, 1'b0);
    retune(16'sh7fff, 8'd255, 8'd255, 8'd255);
    run_phase(220, 90, 1'b1);
    retune(16'sh8000, 8'd255, 8'd255, 8'd255);
    run_phase(150, 90, 1'b1);
    retune(16'sh0000, 8'd0, 8'd0, 8'd0);
    run_phase(120, 30, 1'b0);

    // Results back up while the drain side holds off, so the request side stalls.
    retune_random();
    recv_hold = 60;
    repeat (40) send_request(random_request(100, 1'b0), 0);
    run_phase(150, 25, 1'b0);
    retune_random();
    run_phase(150, 25, 1'b0);

    cmd.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : drain
    int stall;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (recv_hold > 0) begin
        stall = recv_hold;
        recv_hold = 0;
      end else begin
        stall = draw_gap(recv_calm);
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  always @(posedge clk) begin : scoreboard
    tick_report_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result: count_one=%0d count_two=%0d drive_right=%0d drive_left=%0d",
                   res.count_one, res.count_two, res.drive_right, res.drive_left);
        end
      end else begin
        want = pending_reports.pop_front();
        if (res.count_one !== want.count_one || res.count_two !== want.count_two ||
            res.drive_right !== want.drive_right || res.drive_left !== want.drive_left) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.count_one, want.count_two, want.drive_right, want.drive_left,
                     res.count_one, res.count_two, res.drive_right, res.drive_left);
          end
        end
      end
    end
  end

endmodule

[dual_encoder_pi_speed_control_unit.f]
rtl/core/dpsc_pkg.sv
rtl/core/dpsc_in_if.sv
rtl/core/dpsc_out_if.sv
rtl/core/dpsc_enc.sv
rtl/core/dpsc_pi.sv
rtl/core/dual_encoder_pi_speed_control_unit.sv
sim/testbench.sv
